### rtl/core/fpa_pkg.sv
// Shared constants, types and arithmetic helpers of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int WORD_W = 32;
	// Width of the scaled dividend and of the full quotient.
	localparam int NUM_W = WORD_W + FRACTION_BITS;
	localparam logic [63:0] MUL_HALF = (64'(1) << FRACTION_BITS) >> 1;
	localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} opcode_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              ovf;
	} sat_t;

	// Fields that travel beside the divider through the pipeline.
	typedef struct packed {
		opcode_t           op;
		logic [WORD_W-1:0] res;
		logic              cmp;
		logic              ovf;
		logic              neg;
		logic              a_neg;
		logic              a_zero;
	} side_t;

	function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] x);
		magnitude = x[WORD_W-1] ? (~x + 1'b1) : x;
	endfunction

	// Applies a sign to a magnitude and clamps to the signed 32-bit range.
	function automatic sat_t sign_saturate(input logic [63:0] mag, input logic neg);
		sat_t s;
		s.ovf = 1'b0;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				s.value = SAT_NEG;
				s.ovf = 1'b1;
			end else begin
				s.value = ~mag[WORD_W-1:0] + 1'b1;
			end
		end else begin
			if (mag > 64'h7FFF_FFFF) begin
				s.value = SAT_POS;
				s.ovf = 1'b1;
			end else begin
				s.value = mag[WORD_W-1:0];
			end
		end
		sign_saturate = s;
	endfunction

endpackage

### rtl/core/fpa_if.sv
// Request and response channel interfaces of the fixed-point ALU.
`timescale 1ns / 1ps
interface fpa_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	modport source (output valid, opcode, operand_a, operand_b, input ready);
	modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        compare_true;
	logic        overflow;
	logic        divide_by_zero;
	modport source (output valid, result, compare_true, overflow, divide_by_zero,
		input ready);
	modport sink (input valid, result, compare_true, overflow, divide_by_zero,
		output ready);
endinterface

### rtl/core/fpa_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module fpa_div (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [fpa_pkg::NUM_W-1:0]            num,
	input  logic [fpa_pkg::WORD_W-1:0]           den,
	output logic [fpa_pkg::NUM_W-1:0]            quo,
	output logic [fpa_pkg::WORD_W-1:0]           rem,
	output logic [fpa_pkg::WORD_W-1:0]           den_out
);
	import fpa_pkg::*;

	logic [NUM_W-1:0]  num_s [NUM_W];
	logic [NUM_W-1:0]  quo_s [NUM_W];
	logic [WORD_W-1:0] rem_s [NUM_W];
	logic [WORD_W-1:0] den_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [NUM_W-1:0]  num_in;
		logic [NUM_W-1:0]  quo_in;
		logic [WORD_W-1:0] rem_in;
		logic [WORD_W-1:0] den_in;
		logic [WORD_W:0]   trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign num_in = num;
			assign quo_in = '0;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
		end

		// The partial remainder stays below the divisor, so 33 bits hold the trial.
		assign trial = {rem_in, num_in[NUM_W-1]};
		assign ge = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= num_in << 1;
				quo_s[k] <= {quo_in[NUM_W-2:0], ge};
				rem_s[k] <= ge ? WORD_W'(trial - {1'b0, den_in}) : trial[WORD_W-1:0];
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[NUM_W-1];
	assign rem = rem_s[NUM_W-1];
	assign den_out = den_s[NUM_W-1];

endmodule

### rtl/core/fixed_point_alu.sv
// Top level of the pipelined signed Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
// The ALU takes one request per cycle unless stalled and returns exactly one
// response per request, in order; every opcode of this Q24.8 ALU shares
// one pipeline depth, and that depth is set by the divider,
// which resolves one quotient bit per stage over 32 + FRACTION_BITS stages.
// The whole pipeline advances whenever the output register is empty or being
// drained, so a stalled response holds every stage in place. Multiply and
// divide round to nearest with ties away from zero and saturate with
// overflow set; a zero divisor saturates by the sign of a nonzero dividend,
// gives zero for a zero dividend and sets divide_by_zero.
module fixed_point_alu (
	input  logic          clk,
	input  logic          arst_n,
	fpa_req_if.sink       req,
	fpa_rsp_if.source     rsp
);
	import fpa_pkg::*;

	logic              en;
	logic              valid_s [NUM_W];
	side_t             side_s [NUM_W];
	logic [63:0]       prod_s1;
	side_t             side_in;
	side_t             side_mul;
	sat_t              mul_sat;
	logic [63:0]       mul_q;
	logic [WORD_W-1:0] a;
	logic [WORD_W-1:0] b;
	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	logic              a_lt_b;
	logic              b_lt_a;
	logic [NUM_W-1:0]  div_quo;
	logic [WORD_W-1:0] div_rem;
	logic [WORD_W-1:0] div_den;
	logic [NUM_W:0]    div_round;
	sat_t              div_sat;
	logic              valid_q;
	logic [WORD_W-1:0] result_q;
	logic              cmp_q;
	logic              ovf_q;
	logic              dz_q;

	assign en = !valid_q || rsp.ready;
	assign req.ready = en;

	assign a = req.operand_a;
	assign b = req.operand_b;
	assign mag_a = magnitude(a);
	assign mag_b = magnitude(b);
	assign a_lt_b = $signed(a) < $signed(b);
	assign b_lt_a = $signed(b) < $signed(a);

	// Everything but multiply and divide is settled at the input.
	always_comb begin
		side_in = '0;
		side_in.op = opcode_t'(req.opcode);
		side_in.neg = a[WORD_W-1] ^ b[WORD_W-1];
		side_in.a_neg = a[WORD_W-1];
		side_in.a_zero = (a == '0);
		case (opcode_t'(req.opcode))
			OP_ADD:      side_in.res = a + b;
			OP_SUB:      side_in.res = a - b;
			OP_GT:       side_in.cmp = b_lt_a;
			OP_LT:       side_in.cmp = a_lt_b;
			OP_GE:       side_in.cmp = !a_lt_b;
			OP_LE:       side_in.cmp = !b_lt_a;
			OP_EQ:       side_in.cmp = (a == b);
			OP_NE:       side_in.cmp = (a != b);
			OP_MIN:      side_in.res = a_lt_b ? a : b;
			OP_MAX:      side_in.res = b_lt_a ? a : b;
			OP_INC:      side_in.res = a + 1'b1;
			OP_DEC:      side_in.res = a - 1'b1;
			OP_FROM_INT: side_in.res = a << FRACTION_BITS;
			OP_TO_INT:   side_in.res = WORD_W'($signed(a) >>> FRACTION_BITS);
			default:     side_in.res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(mag_a) * 64'(mag_b);
		end
	end

	// Rounding and saturation of the product happen in the second stage.
	assign mul_q = (prod_s1 + MUL_HALF) >> FRACTION_BITS;
	assign mul_sat = sign_saturate(mul_q, side_s[0].neg && (mul_q != '0));

	always_comb begin
		side_mul = side_s[0];
		if (side_s[0].op == OP_MUL) begin
			side_mul.res = mul_sat.value;
			side_mul.ovf = mul_sat.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= req.valid;
			for (int k = 1; k < NUM_W; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			side_s[1] <= side_mul;
			for (int k = 2; k < NUM_W; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	fpa_div u_div (
		.clk     (clk),
		.en      (en),
		.num     (NUM_W'(mag_a) << FRACTION_BITS),
		.den     (mag_b),
		.quo     (div_quo),
		.rem     (div_rem),
		.den_out (div_den)
	);

	// Round half away from zero: bump the quotient when twice the remainder
	// reaches the divisor.
	assign div_round = {1'b0, div_quo} +
		(NUM_W+1)'({div_rem, 1'b0} >= {1'b0, div_den});
	assign div_sat = sign_saturate(64'(div_round),
		side_s[NUM_W-1].neg && (div_round != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s[NUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= side_s[NUM_W-1].res;
			cmp_q <= side_s[NUM_W-1].cmp;
			ovf_q <= side_s[NUM_W-1].ovf;
			dz_q <= 1'b0;
			if (side_s[NUM_W-1].op == OP_DIV) begin
				if (div_den == '0) begin
					dz_q <= 1'b1;
					ovf_q <= 1'b0;
					if (side_s[NUM_W-1].a_zero) begin
						result_q <= '0;
					end else begin
						result_q <= side_s[NUM_W-1].a_neg ? SAT_NEG : SAT_POS;
					end
				end else begin
					result_q <= div_sat.value;
					ovf_q <= div_sat.ovf;
				end
			end
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.result = result_q;
	assign rsp.compare_true = cmp_q;
	assign rsp.overflow = ovf_q;
	assign rsp.divide_by_zero = dz_q;

endmodule

### rtl/core/fpa_checker.sv
// Port-level assertions of the fixed-point ALU and their binding.
`timescale 1ns / 1ps
module fpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] result,
	input logic        compare_true,
	input logic        overflow,
	input logic        divide_by_zero
);
	import fpa_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result) &&
		$stable(compare_true) && $stable(overflow) && $stable(divide_by_zero))
		else $error("response changed while stalled");

	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && divide_by_zero |-> !overflow && !compare_true)
		else $error("divide by zero flagged together with another flag");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> result == SAT_POS || result == SAT_NEG)
		else $error("overflow without a saturated result");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && compare_true |-> result == '0 && !overflow)
		else $error("comparison response carries a value");

	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && divide_by_zero |->
		result == SAT_POS || result == SAT_NEG || result == '0)
		else $error("divide by zero result not saturated");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.result         (rsp.result),
	.compare_true   (rsp.compare_true),
	.overflow       (rsp.overflow),
	.divide_by_zero (rsp.divide_by_zero)
);
